[sv/qmco_pkg.sv]
`timescale 1ns / 1ps
package qmco_pkg;

	// Internal map width; the sample field is 32 bits, so saturation never
	// goes beyond 32 bits.
	localparam int VALUE_WIDTH = 32;
	localparam int SAT_BITS    = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

	localparam int DATA_W      = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int STEP_W      = 4;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] CFG_COEF_A = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_COEF_B = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_COEF_C = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_ISR    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SEED   = 3'd4;

	localparam logic signed [DATA_W-1:0] COEF_A_RST = 32'sd16777216;
	localparam logic signed [DATA_W-1:0] COEF_B_RST = -32'sd16777216;
	localparam logic signed [DATA_W-1:0] COEF_C_RST = -32'sd12582912;
	localparam logic [DATA_W-1:0]        ISR_RST    = 32'd89478;

	// 1.0 in Q3.29 and the step clip level in Q20.44.
	localparam logic signed [DATA_W-1:0] PHASE_ONE = 32'sd536870912;
	localparam logic signed [63:0]       STEP_CLIP = 64'sd17592186044416;

	localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAT_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_HZ_ISR,
		MUL_Y_Y,
		MUL_B_Y,
		MUL_A_SQLO,
		MUL_A_SQHI
	} mul_sel_t;

	typedef enum logic [2:0] {
		OP_WAIT_IN,
		OP_PHASE,
		OP_SQ,
		OP_LOAD,
		OP_ADD,
		OP_SHC,
		OP_SAT,
		OP_EMIT
	} dp_op_t;

	typedef enum logic [1:0] {
		JC_NEXT,
		JC_IN,
		JC_NOTRIG,
		JC_OUT
	} jump_t;

	typedef struct packed {
		mul_sel_t          mul;
		dp_op_t            op;
		jump_t             jump;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic in_fire;
		logic out_free;
		logic trig;
	} status_t;

	localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
	localparam logic [STEP_W-1:0] STEP_EMIT = 4'd9;

	// Microprogram. Each product is registered at the end of its step, and a
	// step that consumes a product reads the most recent one.
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t c;
		c = '{MUL_NONE, OP_WAIT_IN, JC_IN, STEP_IDLE};
		unique case (step)
			4'd0: c = '{MUL_NONE,   OP_WAIT_IN, JC_IN,     STEP_IDLE};
			4'd1: c = '{MUL_HZ_ISR, OP_SAT,     JC_NEXT,   STEP_IDLE};
			4'd2: c = '{MUL_Y_Y,    OP_PHASE,   JC_NOTRIG, STEP_EMIT};
			4'd3: c = '{MUL_B_Y,    OP_SQ,      JC_NEXT,   STEP_IDLE};
			4'd4: c = '{MUL_A_SQLO, OP_LOAD,    JC_NEXT,   STEP_IDLE};
			4'd5: c = '{MUL_A_SQHI, OP_ADD,     JC_NEXT,   STEP_IDLE};
			4'd6: c = '{MUL_NONE,   OP_SHC,     JC_NEXT,   STEP_IDLE};
			4'd7: c = '{MUL_NONE,   OP_ADD,     JC_NEXT,   STEP_IDLE};
			4'd8: c = '{MUL_NONE,   OP_SAT,     JC_NEXT,   STEP_IDLE};
			4'd9: c = '{MUL_NONE,   OP_EMIT,    JC_OUT,    STEP_IDLE};
			default: c = '{MUL_NONE, OP_WAIT_IN, JC_IN, STEP_IDLE};
		endcase
		return c;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_value(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = v;
		if (v > SAT_HI) begin
			r = SAT_HI;
		end else if (v < SAT_LO) begin
			r = SAT_LO;
		end
		return r[DATA_W-1:0];
	endfunction

endpackage

[sv/qmco_ifs.sv]
`timescale 1ns / 1ps
interface qmco_freq_if;
	logic        valid;
	logic        ready;
	logic [31:0] frequency;

	modport source(output valid, output frequency, input ready);
	modport sink(input valid, input frequency, output ready);
endinterface

interface qmco_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] sample;
	logic        updated;

	modport source(output valid, output sample, output updated, input ready);
	modport sink(input valid, input sample, input updated, output ready);
endinterface

interface qmco_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

[sv/qmco_sequencer.sv]
`timescale 1ns / 1ps
module qmco_sequencer
	import qmco_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output ctrl_t   ctrl
);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_next;

	assign ctrl = ucode(step_q);

	always_comb begin
		step_next = step_q + 4'd1;
		unique case (ctrl.jump)
			JC_NEXT:   step_next = step_q + 4'd1;
			JC_IN:     step_next = status.in_fire ? step_q + 4'd1 : step_q;
			JC_NOTRIG: step_next = status.trig ? step_q + 4'd1 : ctrl.target;
			JC_OUT:    step_next = status.out_free ? ctrl.target : step_q;
			default:   step_next = STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

[sv/qmco_datapath.sv]
`timescale 1ns / 1ps
module qmco_datapath
	import qmco_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  ctrl_t  ctrl,
	output status_t status,
	qmco_freq_if.sink     freq_ch,
	qmco_result_if.source result_ch,
	qmco_cfg_if.sink      cfg
);

	logic signed [DATA_W-1:0] coef_a_q, coef_b_q, coef_c_q;
	logic [DATA_W-1:0]        isr_q;
	logic signed [DATA_W-1:0] hz_q, phase_q, map_q;
	logic signed [63:0]       prod_q, acc_q;
	logic [38:0]              sq_q;
	logic                     trig_q;
	logic                     out_valid_q, out_updated_q;
	logic [DATA_W-1:0]        out_sample_q;

	logic signed [32:0]       mul_x, mul_y;
	logic signed [65:0]       product;
	logic signed [DATA_W-1:0] step, phase_wrapped;
	logic                     trig, in_fire, out_free, cfg_fire;

	assign in_fire  = (ctrl.op == OP_WAIT_IN) && freq_ch.valid;
	assign out_free = !out_valid_q || result_ch.ready;
	assign cfg_fire = cfg.valid;

	assign freq_ch.ready     = (ctrl.op == OP_WAIT_IN);
	assign cfg.ready         = 1'b1;
	assign result_ch.valid   = out_valid_q;
	assign result_ch.sample  = out_sample_q;
	assign result_ch.updated = out_updated_q;

	assign status = '{in_fire: in_fire, out_free: out_free, trig: trig};

	// Operand selection for the one shared 33 x 33 multiplier.
	always_comb begin
		mul_x = '0;
		mul_y = '0;
		case (ctrl.mul)
			MUL_HZ_ISR: begin
				mul_x = {hz_q[DATA_W-1], hz_q};
				mul_y = {1'b0, isr_q};
			end
			MUL_Y_Y: begin
				mul_x = {map_q[DATA_W-1], map_q};
				mul_y = {map_q[DATA_W-1], map_q};
			end
			MUL_B_Y: begin
				mul_x = {coef_b_q[DATA_W-1], coef_b_q};
				mul_y = {map_q[DATA_W-1], map_q};
			end
			MUL_A_SQLO: begin
				mul_x = {coef_a_q[DATA_W-1], coef_a_q};
				mul_y = {9'b0, sq_q[23:0]};
			end
			MUL_A_SQHI: begin
				mul_x = {coef_a_q[DATA_W-1], coef_a_q};
				mul_y = {18'b0, sq_q[38:24]};
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end

	assign product = mul_x * mul_y;

	// Phase step from the clipped frequency product, and the wrap test.
	always_comb begin
		if (prod_q >= STEP_CLIP) begin
			step = PHASE_ONE;
		end else if (prod_q <= -STEP_CLIP) begin
			step = -PHASE_ONE;
		end else begin
			step = prod_q[46:15];
		end
		if (!hz_q[DATA_W-1]) begin
			trig          = (phase_q >= PHASE_ONE);
			phase_wrapped = trig ? phase_q - PHASE_ONE : phase_q;
		end else begin
			trig          = (phase_q <= 32'sd0);
			phase_wrapped = trig ? phase_q + PHASE_ONE : phase_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul != MUL_NONE) begin
			prod_q <= product[63:0];
		end
		case (ctrl.op)
			OP_WAIT_IN: begin
				if (in_fire) begin
					hz_q <= freq_ch.frequency;
				end
			end
			OP_SQ:   sq_q  <= prod_q[62:24];
			OP_LOAD: acc_q <= prod_q;
			OP_ADD:  acc_q <= acc_q + prod_q;
			OP_SHC:  acc_q <= (acc_q >>> 24) + $signed({{32{coef_c_q[DATA_W-1]}}, coef_c_q});
			default: ;
		endcase
		if ((ctrl.op == OP_EMIT) && out_free) begin
			out_sample_q  <= map_q;
			out_updated_q <= trig_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q    <= COEF_A_RST;
			coef_b_q    <= COEF_B_RST;
			coef_c_q    <= COEF_C_RST;
			isr_q       <= ISR_RST;
			phase_q     <= PHASE_ONE;
			map_q       <= '0;
			trig_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_fire) begin
				case (cfg.index)
					CFG_COEF_A: coef_a_q <= cfg.data;
					CFG_COEF_B: coef_b_q <= cfg.data;
					CFG_COEF_C: coef_c_q <= cfg.data;
					CFG_ISR:    isr_q    <= cfg.data;
					CFG_SEED:   map_q    <= sat_value({{32{cfg.data[31]}}, cfg.data});
					default: ;
				endcase
			end
			if (ctrl.op == OP_PHASE) begin
				phase_q <= phase_wrapped + step;
				trig_q  <= trig;
			end
			if ((ctrl.op == OP_SAT) && (ctrl.mul == MUL_NONE)) begin
				map_q <= sat_value(acc_q);
			end
			if ((ctrl.op == OP_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[sv/quadratic_map_chaos_oscillator_core.sv]
`timescale 1ns / 1ps
// Quadratic-map chaotic oscillator.
// Each request on freq_ch carries one audio sample of a signed update rate
// (Q20.12 Hz). A phase accumulator advances by frequency / sample rate; each
// time it wraps, the held value y becomes a*y*y + b*y + c (Q8.24, saturated).
// Every request yields exactly one request on result_ch with the held value
// and a flag that tells whether it was recomputed for this sample.
// Registers are written over cfg (index 0..4: coef_a, coef_b, coef_c,
// inv_sample_rate, seed_value); a seed write loads the map value at once.
// cfg is always ready; the user must write it only while the block is idle,
// which the block itself does not enforce. A microcoded sequencer steps one
// shared 33 x 33 multiplier through the work: a sample without a wrap goes
// from the phase step straight to emit, one with a wrap first runs the map
// update; the next request is taken in the idle step after emit, so a new
// sample is never taken before the last one is in the output register.
// The output register holds a result while the receiver stalls; the
// sequencer waits on the emit step until that register is free.
// Reset restores the register defaults, the phase to 1.0 and the map to 0.
module quadratic_map_chaos_oscillator_core
	import qmco_pkg::*;
(
	input logic clk,
	input logic arst_n,
	qmco_freq_if.sink     freq_ch,
	qmco_result_if.source result_ch,
	qmco_cfg_if.sink      cfg
);

	ctrl_t   ctrl;
	status_t status;

	// Step counter and microprogram ROM.
	qmco_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// Registers, shared multiplier, accumulator and output register.
	qmco_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.status    (status),
		.freq_ch   (freq_ch),
		.result_ch (result_ch),
		.cfg       (cfg)
	);

endmodule

[tb/quadratic_map_chaos_oscillator_core_test.sv]
`timescale 1ns / 1ps

// One expected output request: the held map value and its update flag.
typedef struct packed {
	logic [31:0] sample;
	logic        updated;
} map_result_t;

// Tracks the phase accumulator and the map value of the oscillator and keeps
// the results that the block still owes, oldest first.
class chaos_map_tracker;
	int          coef_a;
	int          coef_b;
	int          coef_c;
	int unsigned inv_rate;
	int          phase;
	int          map_value;
	map_result_t pending_samples[$];
	int          mismatch_count;

	function new();
		coef_a = qmco_pkg::COEF_A_RST;
		coef_b = qmco_pkg::COEF_B_RST;
		coef_c = qmco_pkg::COEF_C_RST;
		inv_rate = qmco_pkg::ISR_RST;
		phase = qmco_pkg::PHASE_ONE;
		map_value = 0;
		mismatch_count = 0;
	endfunction

	function int clamp_value(longint v);
		if (v > qmco_pkg::SAT_HI) begin
			return int'(qmco_pkg::SAT_HI);
		end
		if (v < qmco_pkg::SAT_LO) begin
			return int'(qmco_pkg::SAT_LO);
		end
		return int'(v);
	endfunction

	// a*y*y + b*y + c in Q8.24. The square is split at bit 24 so that every
	// partial sum fits in 64 bits; shifts of signed values round down.
	function int next_value(int y);
		longint yl;
		longint sq;
		longint sq_hi;
		longint sq_lo;
		longint low;
		longint sum;
		yl = longint'(y);
		sq = (yl * yl) >>> 24;
		sq_hi = sq >>> 24;
		sq_lo = sq & 64'h0000_0000_00FF_FFFF;
		low = longint'(coef_a) * sq_lo + longint'(coef_b) * yl;
		sum = longint'(coef_a) * sq_hi + (low >>> 24) + longint'(coef_c);
		return clamp_value(sum);
	endfunction

	function void apply_register(logic [2:0] index, logic [31:0] data);
		case (index)
			qmco_pkg::CFG_COEF_A: coef_a = int'($signed(data));
			qmco_pkg::CFG_COEF_B: coef_b = int'($signed(data));
			qmco_pkg::CFG_COEF_C: coef_c = int'($signed(data));
			qmco_pkg::CFG_ISR:    inv_rate = data;
			qmco_pkg::CFG_SEED:   map_value = clamp_value(longint'($signed(data)));
			default: ;
		endcase
	endfunction

	function void note_frequency(logic [31:0] frequency);
		longint      hz;
		longint      product;
		int          step;
		bit          wrapped;
		map_result_t r;
		hz = longint'($signed(frequency));
		product = hz * longint'({32'd0, inv_rate});
		if (product >= qmco_pkg::STEP_CLIP) begin
			step = qmco_pkg::PHASE_ONE;
		end else if (product <= -qmco_pkg::STEP_CLIP) begin
			step = -qmco_pkg::PHASE_ONE;
		end else begin
			step = int'(product >>> 15);
		end
		if (hz >= 0) begin
			wrapped = (phase >= qmco_pkg::PHASE_ONE);
			if (wrapped) begin
				phase = phase - qmco_pkg::PHASE_ONE;
			end
		end else begin
			wrapped = (phase <= 0);
			if (wrapped) begin
				phase = phase + qmco_pkg::PHASE_ONE;
			end
		end
		if (wrapped) begin
			map_value = next_value(map_value);
		end
		r.sample = map_value;
		r.updated = wrapped;
		pending_samples.push_back(r);
		phase = phase + step;
	endfunction

	function void check_sample(logic [31:0] sample, logic updated);
		map_result_t e;
		if (pending_samples.size() == 0) begin
			$display("%0t: unexpected result: expected none, actual sample %h updated %b",
				$time, sample, updated);
			mismatch_count++;
			return;
		end
		e = pending_samples.pop_front();
		if (sample !== e.sample) begin
			$display("%0t: sample mismatch: expected %h, actual %h", $time, e.sample, sample);
			mismatch_count++;
		end
		if (updated !== e.updated) begin
			$display("%0t: updated mismatch: expected %b, actual %b",
				$time, e.updated, updated);
			mismatch_count++;
		end
	endfunction
endclass

module quadratic_map_chaos_oscillator_core_test;
	import qmco_pkg::*;

	// Register indexes past the end of the list; the block must ignore them.
	localparam logic [2:0] CFG_INDEX_TOP = 3'd7;

	// Receiver hold-off that forces the block to back up into its input, and
	// the watchdog limit: several times the longest legal quiet stretch.
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TAIL_CYCLES    = 20;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_SPARSE
	} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	qmco_freq_if   freq_ch();
	qmco_result_if result_ch();
	qmco_cfg_if    cfg_ch();

	chaos_map_tracker tracker;

	// Raised by the stimulus, cleared by the receiver once its hold is over.
	bit hold_request = 1'b0;

	quadratic_map_chaos_oscillator_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.freq_ch(freq_ch),
		.result_ch(result_ch),
		.cfg(cfg_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Offers one frequency request and returns at the falling edge after it
	// was taken, with valid still high. The caller either offers the next
	// request in that same step or lowers valid, never both.
	task automatic send_frequency(input logic [31:0] value);
		freq_ch.valid <= 1'b1;
		freq_ch.frequency <= value;
		do @(posedge clk); while (!freq_ch.ready);
		tracker.note_frequency(value);
		@(negedge clk);
	endtask

	// Same contract as send_frequency, for the register write channel.
	task automatic write_register(input logic [2:0] index, input logic [31:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		tracker.apply_register(index, data);
		@(negedge clk);
	endtask

	task automatic program_registers(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] rate, input logic [31:0] seed);
		write_register(CFG_COEF_A, a);
		write_register(CFG_COEF_B, b);
		write_register(CFG_COEF_C, c);
		write_register(CFG_ISR, rate);
		write_register(CFG_SEED, seed);
		cfg_ch.valid <= 1'b0;
	endtask

	// The sender stops offering and waits until every owed result has been
	// taken. Every request causes one result, so an empty store means the
	// sequencer is back in its idle step; a margin follows.
	task automatic drain_results();
		freq_ch.valid <= 1'b0;
		while (tracker.pending_samples.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	// Coefficients mostly near the interesting range of +/-2.0, sometimes
	// anywhere in 32 bits, which drives the map into saturation.
	function automatic logic [31:0] pick_coef();
		if ($urandom_range(0, 3) == 0) begin
			return $urandom();
		end
		return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
	endfunction

	function automatic logic [31:0] pick_rate();
		case ($urandom_range(0, 2))
			0: return $urandom();
			1: return $urandom_range(1, 32'h0010_0000);
			default: return $urandom_range(20000, 200000);
		endcase
	endfunction

	// Frequencies of random magnitude with the sign of the current run, so
	// that the phase keeps moving one way and wraps; some full-width noise
	// and the corner values are mixed in.
	function automatic logic [31:0] pick_frequency(input bit negative);
		int unsigned mode;
		int unsigned width;
		logic [31:0] mag;
		mode = $urandom_range(0, 9);
		if (mode < 3) begin
			return $urandom();
		end
		if (mode < 9) begin
			width = $urandom_range(1, 31);
			mag = $urandom() & (32'hFFFF_FFFF >> (32 - width));
			return negative ? -mag : mag;
		end
		if (negative) begin
			return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h8000_0000;
		end
		return $urandom_range(0, 1) ? 32'h0000_0000 : 32'h7FFF_FFFF;
	endfunction

	// Random requests in bursts of random length. Gaps between bursts are
	// random, and about one burst in four runs straight into the next one.
	task automatic run_random(input int count, input bit long_hold);
		int left;
		int burst;
		int gap;
		bit negative;
		left = count;
		negative = 1'b0;
		if (long_hold) begin
			hold_request = 1'b1;
		end
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			if (burst > left) begin
				burst = left;
			end
			if ($urandom_range(0, 3) == 0) begin
				negative = !negative;
			end
			repeat (burst) send_frequency(pick_frequency(negative));
			left -= burst;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				freq_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		freq_ch.valid <= 1'b0;
	endtask

	task automatic run_random_phase(input int count, input bit long_hold,
			input bit spare_writes);
		logic [2:0] index;
		if (spare_writes) begin
			// Writes past the end of the register list must change nothing.
			for (index = CFG_SEED + 3'd1; index <= CFG_INDEX_TOP; index++) begin
				write_register(index, $urandom());
				if (index == CFG_INDEX_TOP) begin
					break;
				end
			end
		end
		program_registers(pick_coef(), pick_coef(), pick_coef(), pick_rate(),
			($urandom_range(0, 3) == 0) ? $urandom() : pick_coef());
		run_random(count, long_hold);
		drain_results();
	endtask

	// Receiver: its readiness follows a pattern that is picked anew after a
	// random span, from always ready to ready one cycle in four. On request it
	// holds off for a long stretch, counted here, so that the output
	// register fills and the block stops taking frequency requests.
	initial begin
		stall_mode_t mode;
		int          span;
		int unsigned tick;
		mode = STALL_NONE;
		span = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_request = 1'b0;
			end else begin
				if (span == 0) begin
					mode = stall_mode_t'($urandom_range(0, 2));
					span = $urandom_range(16, 96);
				end
				span--;
				tick++;
				case (mode)
					STALL_NONE:   result_ch.ready <= 1'b1;
					STALL_RANDOM: result_ch.ready <= $urandom_range(0, 1);
					default:      result_ch.ready <= (tick % 4 == 0);
				endcase
			end
		end
	end

	// Results are checked at the rising edge where the request is taken.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			tracker.check_sample(result_ch.sample, result_ch.updated);
		end
	end

	// Watchdog: ends the run if no request moves on any channel for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((freq_ch.valid && freq_ch.ready) || (result_ch.valid && result_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("%0t: no request taken for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		logic [31:0] corner_rates [18];
		freq_ch.valid = 1'b0;
		freq_ch.frequency = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		result_ch.ready = 1'b0;
		arst_n = 1'b0;
		tracker = new();

		// Directed requests under the reset settings. The phase starts at
		// 1.0, so a zero frequency wraps at once and a negative one wraps
		// after that; then the field extremes, steps just under 1.0, and a half
		// step that wraps every other sample.
		corner_rates = '{
			32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'd196608000, 32'd196608000, -32'sd196608000, -32'sd196608000,
			32'd98304000, 32'd98304000, 32'd98304000, -32'sd98304000,
			32'h0000_1000, 32'hFFFF_F000
		};

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (corner_rates[i]) begin
			send_frequency(corner_rates[i]);
		end
		drain_results();

		// Reset coefficients with the largest reciprocal rate: a frequency above
		// 1.0 Hz in magnitude gives a step clipped to +/-1.0.
		program_registers(COEF_A_RST, COEF_B_RST, COEF_C_RST, 32'hFFFF_FFFF, 32'h0040_0000);
		run_random(80, 1'b0);
		drain_results();

		// All coefficients and the seed at the top of the range: the map
		// overflows and must saturate high. The smallest rate makes wraps rare.
		program_registers(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001,
			32'h7FFF_FFFF);
		run_random(60, 1'b0);
		drain_results();

		// All at the bottom of the range, saturating low, with a zero rate so
		// that the phase only moves on a wrap.
		program_registers(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000,
			32'h8000_0000);
		run_random(60, 1'b0);
		drain_results();

		// Random settings. The first phase also writes the unused indexes
		// and holds off the receiver while the sender keeps offering.
		run_random_phase(90, 1'b1, 1'b1);
		run_random_phase(90, 1'b0, 1'b0);
		run_random_phase(90, 1'b0, 1'b0);
		run_random_phase(90, 1'b0, 1'b0);
		run_random_phase(90, 1'b0, 1'b0);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.mismatch_count == 0 && tracker.pending_samples.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
